// File: rtl/ridba_pkg.sv
// shared types and constants for the rule id bitmap allocator
// no dependencies; used by rule_id_bitmap_allocator
`default_nettype none

package ridba_pkg;

  localparam int MAX_RULES_DEFAULT  = 1024;
  localparam int SLAB_WIDTH_DEFAULT = 64;

  localparam int OPCODE_W  = 2;
  localparam int RULE_ID_W = 10;
  localparam int STATUS_W  = 3;
  localparam int LIMIT_W   = 11;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [LIMIT_W-1:0] RULE_LIMIT_RESET = 11'd1024;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FLUSH = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_DISABLED   = 3'd1,
    ST_NO_FREE    = 3'd2,
    ST_INVALID    = 3'd3,
    ST_NOT_ACTIVE = 3'd4,
    ST_DEV_ERR    = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    REG_FLOW_ENABLE = 1'b0,
    REG_RULE_LIMIT  = 1'b1
  } reg_index_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

`default_nettype wire

// File: rtl/rule_id_bitmap_allocator.sv
// rule id allocator top level: free bitmap memory, summary bits, control
// depends on ridba_pkg
`default_nettype none

// Hands out the lowest free rule ID below the configured limit, frees single
// IDs and flushes the whole pool. The free bitmap sits in a one-port
// synchronous memory of MAX_RULES/SLAB_WIDTH (rounded up) slabs. The slab is
// read into rd_data at the edge that accepts the request; in the execute
// state it is then modified, written back and the response is registered. The
// request side stalls during the execute state, which is held for as long as
// the previous response is still stalled at the output. A flush takes effect
// at once through one written-since-flush flag per slab, so no clearing pass
// is needed after reset or flush. Registers: 0x0 flow_enable, 0x4 rule_limit.
module rule_id_bitmap_allocator #(
  parameter int MAX_RULES  = ridba_pkg::MAX_RULES_DEFAULT,
  parameter int SLAB_WIDTH = ridba_pkg::SLAB_WIDTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ridba_pkg::APB_AW-1:0]      paddr,
  input  wire logic [ridba_pkg::APB_DW-1:0]      pwdata,
  output logic      [ridba_pkg::APB_DW-1:0]      prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ridba_pkg::OPCODE_W-1:0]    opcode,
  input  wire logic [ridba_pkg::RULE_ID_W-1:0]   rule_id_in,
  input  wire logic                              device_ok,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [ridba_pkg::STATUS_W-1:0]    status,
  output logic      [ridba_pkg::RULE_ID_W-1:0]   rule_id_out
);

  localparam int NUM_SLABS = (MAX_RULES + SLAB_WIDTH - 1) / SLAB_WIDTH;
  localparam int SW        = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
  localparam int BW        = $clog2(SLAB_WIDTH);
  localparam int LIM_W     = $clog2(MAX_RULES + 1);
  localparam int CW        = (LIM_W > ridba_pkg::LIMIT_W) ? LIM_W : ridba_pkg::LIMIT_W;
  localparam int QSH       = CW + BW;
  localparam int RW        = CW + 2;
  localparam int RECIP     = ((1 << QSH) + SLAB_WIDTH - 1) / SLAB_WIDTH;
  localparam int PW        = CW + RW;

  localparam logic [CW-1:0] MAX_RULES_C  = CW'(MAX_RULES);
  localparam logic [CW-1:0] SLAB_WIDTH_C = CW'(SLAB_WIDTH);
  localparam logic [RW-1:0] RECIP_C      = RW'(RECIP);

  // configuration
  logic                               flow_enable;
  logic [ridba_pkg::LIMIT_W-1:0]      rule_limit;
  logic                               cfg_wr;
  logic [CW-1:0]                      limit_ext;
  logic [CW-1:0]                      lim;

  // state
  ridba_pkg::state_t                  state, state_next;
  logic [SLAB_WIDTH-1:0]              mem [NUM_SLABS];
  logic [SLAB_WIDTH-1:0]              rd_data;
  logic [NUM_SLABS-1:0]               slab_valid;
  logic [NUM_SLABS-1:0]               has_free;
  logic [LIM_W-1:0]                   active_count;
  logic                               fault_latched;

  // request registers
  logic [ridba_pkg::OPCODE_W-1:0]     opcode_q;
  logic [CW-1:0]                      id_q;
  logic                               dev_ok_q;
  logic [SW-1:0]                      slab_q;
  logic                               any_free_q;

  // accept side
  logic                               accept;
  logic [CW-1:0]                      id_in_ext;
  logic [PW-1:0]                      quot_prod;
  logic [SW-1:0]                      free_slab;
  logic [SW-1:0]                      first_slab;
  logic [SW-1:0]                      rd_addr;

  // execute side
  logic                               fire;
  logic [SLAB_WIDTH-1:0]              word;
  logic [CW-1:0]                      base;
  logic [CW-1:0]                      id_diff;
  logic [BW-1:0]                      bit_pos;
  logic [BW-1:0]                      first_bit;
  logic [CW-1:0]                      alloc_id;
  logic [SLAB_WIDTH-1:0]              new_word;
  logic                               wr_en;
  logic                               do_flush;
  logic                               set_fault;
  logic                               inc_active;
  logic                               dec_active;
  logic [ridba_pkg::STATUS_W-1:0]     res_status;
  logic [CW-1:0]                      res_id;

  function automatic logic [SLAB_WIDTH-1:0] reset_word(input logic [CW-1:0] slab_base);
    logic [SLAB_WIDTH-1:0] w;
    for (int b = 0; b < SLAB_WIDTH; b++) begin
      w[b] = (slab_base + CW'(b)) < MAX_RULES_C;
    end
    return w;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_enable <= 1'b0;
      rule_limit  <= ridba_pkg::RULE_LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (ridba_pkg::reg_index_t'(paddr[2]))
        ridba_pkg::REG_FLOW_ENABLE: flow_enable <= pwdata[0];
        ridba_pkg::REG_RULE_LIMIT:  rule_limit  <= pwdata[ridba_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridba_pkg::reg_index_t'(paddr[2]))
      ridba_pkg::REG_FLOW_ENABLE: prdata = {{(ridba_pkg::APB_DW-1){1'b0}}, flow_enable};
      ridba_pkg::REG_RULE_LIMIT:
        prdata = {{(ridba_pkg::APB_DW-ridba_pkg::LIMIT_W){1'b0}}, rule_limit};
      default: prdata = '0;
    endcase
  end

  assign limit_ext = CW'(rule_limit);
  assign lim       = (limit_ext > MAX_RULES_C) ? MAX_RULES_C : limit_ext;

  // accept side: slab address
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ridba_pkg::S_IDLE);
  assign id_in_ext = CW'(rule_id_in);

  // slab of a freed id by reciprocal multiplication
  assign quot_prod = PW'(id_in_ext) * PW'(RECIP_C);
  assign free_slab = quot_prod[QSH +: SW];

  always_comb begin
    first_slab = '0;
    for (int i = NUM_SLABS - 1; i >= 0; i--) begin
      if (has_free[i]) first_slab = SW'(i);
    end
  end

  assign rd_addr = (opcode == ridba_pkg::OP_ALLOC) ? first_slab : free_slab;

  always_ff @(posedge clk) begin
    if (accept) begin
      opcode_q   <= opcode;
      id_q       <= id_in_ext;
      dev_ok_q   <= device_ok;
      slab_q     <= rd_addr;
      any_free_q <= |has_free;
    end
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (accept) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[slab_q] <= new_word;
  end

  // execute side
  assign base     = CW'(slab_q) * SLAB_WIDTH_C;
  assign word     = slab_valid[slab_q] ? rd_data : reset_word(base);
  assign id_diff  = id_q - base;
  assign bit_pos  = id_diff[BW-1:0];
  assign alloc_id = base + CW'(first_bit);

  always_comb begin
    first_bit = '0;
    for (int b = SLAB_WIDTH - 1; b >= 0; b--) begin
      if (word[b]) first_bit = BW'(b);
    end
  end

  always_comb begin
    res_status = ridba_pkg::ST_OK;
    res_id     = '0;
    new_word   = word;
    wr_en      = 1'b0;
    do_flush   = 1'b0;
    set_fault  = 1'b0;
    inc_active = 1'b0;
    dec_active = 1'b0;
    if (!flow_enable || fault_latched) begin
      res_status = ridba_pkg::ST_DISABLED;
    end else begin
      case (opcode_q)
        ridba_pkg::OP_ALLOC: begin
          if (!any_free_q || alloc_id >= lim) begin
            res_status = ridba_pkg::ST_NO_FREE;
          end else if (!dev_ok_q) begin
            res_status = ridba_pkg::ST_DEV_ERR;
          end else begin
            new_word[first_bit] = 1'b0;
            wr_en      = fire;
            inc_active = fire;
            res_id     = alloc_id;
          end
        end
        ridba_pkg::OP_FREE: begin
          if (id_q >= lim) begin
            res_status = ridba_pkg::ST_INVALID;
          end else if (word[bit_pos]) begin
            res_status = ridba_pkg::ST_NOT_ACTIVE;
          end else if (!dev_ok_q) begin
            res_status = ridba_pkg::ST_DEV_ERR;
          end else begin
            new_word[bit_pos] = 1'b1;
            wr_en      = fire;
            dec_active = fire && (active_count != '0);
          end
        end
        ridba_pkg::OP_FLUSH: begin
          do_flush = fire;
          if (active_count != '0 && !dev_ok_q) begin
            res_status = ridba_pkg::ST_DEV_ERR;
            set_fault  = fire;
          end
        end
        default: res_status = ridba_pkg::ST_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slab_valid    <= '0;
      has_free      <= '1;
      active_count  <= '0;
      fault_latched <= 1'b0;
    end else begin
      if (do_flush) begin
        slab_valid   <= '0;
        has_free     <= '1;
        active_count <= '0;
      end else begin
        if (wr_en) begin
          slab_valid[slab_q] <= 1'b1;
          has_free[slab_q]   <= |new_word;
        end
        if (inc_active) active_count <= active_count + LIM_W'(1);
        if (dec_active) active_count <= active_count - LIM_W'(1);
      end
      if (set_fault) fault_latched <= 1'b1;
    end
  end

  // request sequencing
  assign fire = (state == ridba_pkg::S_EXEC) && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) state <= ridba_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ridba_pkg::S_IDLE: if (accept) state_next = ridba_pkg::S_EXEC;
      ridba_pkg::S_EXEC: if (fire)   state_next = ridba_pkg::S_IDLE;
      default:                       state_next = ridba_pkg::S_IDLE;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status      <= res_status;
      rule_id_out <= res_id[ridba_pkg::RULE_ID_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: tb/ridba_check_pkg.sv
// rule id pool model and reply checker for the rule id bitmap allocator bench
// depends on ridba_pkg; used by rule_id_bitmap_allocator_test
package ridba_check_pkg;
  import ridba_pkg::*;

  localparam int SLAB_W = SLAB_WIDTH_DEFAULT;
  localparam int NUM_SLABS = MAX_RULES_DEFAULT / SLAB_WIDTH_DEFAULT;
  localparam int REPORT_MAX = 10;

  typedef struct {
    status_t              status;
    logic [RULE_ID_W-1:0] rule_id;
  } reply_t;

  class rule_id_pool_model;
    bit [SLAB_W-1:0]      free_slab [NUM_SLABS];
    bit [NUM_SLABS-1:0]   slab_has_free;
    int unsigned          active;
    bit                   fault;
    bit                   flow_enable;
    bit [LIMIT_W-1:0]     rule_limit;
    reply_t               expected_replies [$];
    int unsigned          failures;
    int unsigned          reported;

    function new();
      release_all();
      fault = 1'b0;
      flow_enable = 1'b0;
      rule_limit = RULE_LIMIT_RESET;
      failures = 0;
      reported = 0;
    endfunction

    function void release_all();
      for (int s = 0; s < NUM_SLABS; s++) begin
        free_slab[s] = '1;
      end
      slab_has_free = '1;
      active = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [APB_DW-1:0] val);
      case (idx)
        REG_FLOW_ENABLE: flow_enable = val[0];
        REG_RULE_LIMIT:  rule_limit = val[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned usable_limit();
      return (rule_limit > MAX_RULES_DEFAULT) ? MAX_RULES_DEFAULT : rule_limit;
    endfunction

    function bit is_free(int unsigned id);
      return free_slab[id / SLAB_W][id % SLAB_W];
    endfunction

    function void mark(int unsigned id, bit free_bit);
      int unsigned s;
      s = id / SLAB_W;
      free_slab[s][id % SLAB_W] = free_bit;
      slab_has_free[s] = |free_slab[s];
    endfunction

    // lowest free id below lim, -1 when none
    function int lowest_free(int unsigned lim);
      for (int s = 0; s < NUM_SLABS; s++) begin
        if (slab_has_free[s]) begin
          for (int b = 0; b < SLAB_W; b++) begin
            if (s * SLAB_W + b >= lim) return -1;
            if (free_slab[s][b]) return s * SLAB_W + b;
          end
        end
      end
      return -1;
    endfunction

    function void note_request(logic [OPCODE_W-1:0] op, logic [RULE_ID_W-1:0] id,
                               logic ok);
      reply_t      want;
      int unsigned lim;
      int          found;
      want.status = ST_OK;
      want.rule_id = '0;
      lim = usable_limit();
      if (!flow_enable || fault) begin
        want.status = ST_DISABLED;
      end else begin
        case (opcode_t'(op))
          OP_ALLOC: begin
            found = lowest_free(lim);
            if (found < 0) begin
              want.status = ST_NO_FREE;
            end else if (!ok) begin
              want.status = ST_DEV_ERR;
            end else begin
              mark(found, 1'b0);
              active++;
              want.rule_id = found[RULE_ID_W-1:0];
            end
          end
          OP_FREE: begin
            if (id >= lim) begin
              want.status = ST_INVALID;
            end else if (is_free(id)) begin
              want.status = ST_NOT_ACTIVE;
            end else if (!ok) begin
              want.status = ST_DEV_ERR;
            end else begin
              mark(id, 1'b1);
              if (active > 0) active--;
            end
          end
          OP_FLUSH: begin
            if (active != 0 && !ok) begin
              want.status = ST_DEV_ERR;
              fault = 1'b1;
            end
            release_all();
          end
          default: want.status = ST_INVALID;
        endcase
      end
      expected_replies.push_back(want);
    endfunction

    function void complain(string msg);
      failures++;
      if (reported < REPORT_MAX) begin
        reported++;
        $display("mismatch: %s", msg);
      end
    endfunction

    function void check_reply(logic [STATUS_W-1:0] st, logic [RULE_ID_W-1:0] id);
      reply_t want;
      if (expected_replies.size() == 0) begin
        complain($sformatf("reply status %0d id %0d with no request waiting", st, id));
      end else begin
        want = expected_replies.pop_front();
        if (st !== want.status || id !== want.rule_id) begin
          complain($sformatf("expected status %0d id %0d, got status %0d id %0d",
                             want.status, want.rule_id, st, id));
        end
      end
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    function int unsigned active_ids();
      return active;
    endfunction

    // a random allocated id, if any
    function bit pick_active(output logic [RULE_ID_W-1:0] id);
      int unsigned start;
      int unsigned i;
      start = $urandom_range(MAX_RULES_DEFAULT - 1, 0);
      id = '0;
      for (int unsigned k = 0; k < MAX_RULES_DEFAULT; k++) begin
        i = (start + k) % MAX_RULES_DEFAULT;
        if (!is_free(i)) begin
          id = i[RULE_ID_W-1:0];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction
  endclass

endpackage

// File: tb/rule_id_bitmap_allocator_test.sv
// self-checking bench for rule_id_bitmap_allocator: directed and random requests
// with random gaps and output stalls, replies checked against a pool model
// depends on ridba_pkg, ridba_check_pkg and the rtl
module rule_id_bitmap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ridba_pkg::*;
  import ridba_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OPCODE_W-1:0]  opcode = '0;
  logic [RULE_ID_W-1:0] rule_id_in = '0;
  logic                 device_ok = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [RULE_ID_W-1:0] rule_id_out;

  logic                 calm = 1'b0;
  int unsigned          cycle_count = 0;
  rule_id_pool_model    pool;

  rule_id_bitmap_allocator dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .rule_id_in(rule_id_in), .device_ok(device_ok),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .rule_id_out(rule_id_out)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99, 0) < 10);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) pool.check_reply(status, rule_id_out);
  end

  task automatic send_request(input logic [OPCODE_W-1:0] op,
                              input logic [RULE_ID_W-1:0] id, input logic ok);
    int unsigned gap;
    if (!calm && $urandom_range(99, 0) < 10) begin
      gap = $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    rule_id_in <= id;
    device_ok <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool.note_request(op, id, ok);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pool.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [APB_DW-1:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pool.write_reg(idx, val);
  endtask

  // mostly allocate and free of live ids, some flushes and stray requests
  task automatic random_phase(input int unsigned count, input int unsigned calm_items);
    int unsigned          pick;
    int unsigned          lim;
    logic [OPCODE_W-1:0]  op;
    logic [RULE_ID_W-1:0] id;
    logic                 ok;
    for (int unsigned i = 0; i < count; i++) begin
      calm <= (i < calm_items);
      pick = $urandom_range(99, 0);
      id = RULE_ID_W'($urandom);
      ok = ($urandom_range(99, 0) >= 8);
      lim = pool.usable_limit();
      if (pick < 45) begin
        op = OP_ALLOC;
      end else if (pick < 85) begin
        op = OP_FREE;
        if ($urandom_range(99, 0) < 80) begin
          void'(pool.pick_active(id));
        end else if ($urandom_range(99, 0) < 30 && lim > 0) begin
          id = RULE_ID_W'(lim - $urandom_range(1, 0));
        end
      end else if (pick < 93) begin
        op = OP_FLUSH;
        if (pool.active_ids() != 0) ok = 1'b1;
      end else if (pick < 96) begin
        op = OP_UNUSED;
      end else begin
        op = OP_FREE;
      end
      send_request(op, id, ok);
    end
    calm <= 1'b0;
  endtask

  initial begin
    pool = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // block not yet enabled
    send_request(OP_ALLOC, RULE_ID_W'($urandom), 1'b1);
    send_request(OP_FREE, '1, 1'b1);
    send_request(OP_FLUSH, '0, 1'b0);
    send_request(OP_UNUSED, '0, 1'b1);
    wait_idle();
    write_reg(REG_FLOW_ENABLE, 1);

    send_request(OP_FLUSH, RULE_ID_W'($urandom), 1'b0);
    send_request(OP_ALLOC, RULE_ID_W'($urandom), 1'b1);
    send_request(OP_ALLOC, RULE_ID_W'($urandom), 1'b0);
    send_request(OP_ALLOC, RULE_ID_W'($urandom), 1'b1);
    send_request(OP_ALLOC, RULE_ID_W'($urandom), 1'b1);
    send_request(OP_FREE, RULE_ID_W'(1), 1'b0);
    send_request(OP_FREE, RULE_ID_W'(1), 1'b1);
    send_request(OP_FREE, RULE_ID_W'(1), 1'b1);
    send_request(OP_FREE, '1, 1'b1);
    send_request(OP_ALLOC, '1, 1'b1);
    send_request(OP_UNUSED, '1, 1'b1);
    wait_idle();

    // no usable id at all
    write_reg(REG_RULE_LIMIT, 0);
    send_request(OP_ALLOC, RULE_ID_W'($urandom), 1'b1);
    send_request(OP_FREE, '0, 1'b1);
    wait_idle();

    // limit beyond the store is clamped
    write_reg(REG_RULE_LIMIT, 2047);
    send_request(OP_FREE, '1, 1'b1);
    send_request(OP_ALLOC, RULE_ID_W'($urandom), 1'b1);
    wait_idle();

    // pool runs dry under a small limit
    write_reg(REG_RULE_LIMIT, 5);
    send_request(OP_ALLOC, RULE_ID_W'($urandom), 1'b1);
    send_request(OP_ALLOC, RULE_ID_W'($urandom), 1'b1);
    send_request(OP_FREE, RULE_ID_W'(5), 1'b1);
    send_request(OP_FREE, RULE_ID_W'(4), 1'b1);
    wait_idle();

    write_reg(REG_RULE_LIMIT, 1024);
    random_phase(250, 80);
    wait_idle();
    write_reg(REG_RULE_LIMIT, 64);
    random_phase(150, 0);
    wait_idle();
    write_reg(REG_RULE_LIMIT, 1);
    random_phase(60, 0);
    wait_idle();
    write_reg(REG_RULE_LIMIT, $urandom_range(200, 2));
    random_phase(150, 20);
    wait_idle();
    write_reg(REG_FLOW_ENABLE, 0);
    random_phase(30, 0);
    wait_idle();
    write_reg(REG_FLOW_ENABLE, 1);
    write_reg(REG_RULE_LIMIT, 2047);
    random_phase(200, 0);
    wait_idle();
    write_reg(REG_RULE_LIMIT, 1024);
    random_phase(60, 0);

    // refused flush with live ids latches the fault
    send_request(OP_ALLOC, RULE_ID_W'($urandom), 1'b1);
    send_request(OP_FLUSH, RULE_ID_W'($urandom), 1'b0);
    send_request(OP_ALLOC, RULE_ID_W'($urandom), 1'b1);
    send_request(OP_FREE, '0, 1'b1);
    send_request(OP_FLUSH, RULE_ID_W'($urandom), 1'b1);
    send_request(OP_UNUSED, RULE_ID_W'($urandom), 1'b1);
    wait_idle();
    repeat (4) @(posedge clk);

    if (pool.failures == 0 && pool.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ridba_pkg.sv
rtl/rule_id_bitmap_allocator.sv
tb/ridba_check_pkg.sv
tb/rule_id_bitmap_allocator_test.sv
